>>> sv/bba_pkg.sv
`default_nettype none
package bba_pkg;
  localparam int unsigned LvlW = 5;
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StTooBig  = 2'd1;
  localparam logic [1:0] StNoMem   = 2'd2;
  localparam logic [1:0] StBadFree = 2'd3;
  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;
endpackage
`default_nettype wire

>>> sv/bba_hdr_mem.sv
`default_nettype none
module bba_hdr_mem #(
  parameter int unsigned AW = 10,
  parameter int unsigned DW = 27
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);
  logic [DW-1:0] mem_q [2**AW];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> sv/buddy_block_allocator.sv
// buddy_block_allocator: binary buddy allocator over back-to-back segments
//
// request channel (req_valid_i/req_ready_o): op_i selects allocate or free,
// req_size_i gives data bytes for allocate, free_addr_i the data address to free
// result channel (rsp_valid_o/rsp_ready_i): data_addr_o and status_o, one per request
// config channel (cfg_valid_i/cfg_ready_o): segment_limit write, only while idle
//
// one request is handled at a time by a small sequencer that drives the header
// memory through its one write port and one read port (read data registered);
// every list edit goes through those ports. a request refused by the early
// checks goes straight to the result, a free refused at the header check right
// after the header read; an allocate searches the free lists, opens a segment if
// no free block fits and the limit allows, and splits level by level; a free
// merges level by level. the block is not ready until the result has been taken.
//
// reset empties the free lists (head valid flags), clears the segment count and sets the limit to 4;
// header memory is not cleared, so a free or a buddy check may read a header that was never written.
// when the receiver stalls the result waits in its output register and no
// new request is taken until it has gone.
`default_nettype none
module buddy_block_allocator #(
  parameter int unsigned LOG2_SEG_BYTES = 12,
  parameter int unsigned NUM_SEGMENTS   = 4,
  parameter int unsigned MIN_LEVEL      = 4,
  parameter int unsigned HEADER_BYTES   = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        req_valid_i,
  output logic             req_ready_o,
  input  wire logic        op_i,
  input  wire logic [12:0] req_size_i,
  input  wire logic [13:0] free_addr_i,
  output logic             rsp_valid_o,
  input  wire logic        rsp_ready_i,
  output logic      [13:0] data_addr_o,
  output logic      [1:0]  status_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  segment_limit_i
);
  localparam int unsigned SegLog  = $clog2(NUM_SEGMENTS) > 0 ? $clog2(NUM_SEGMENTS) : 1;
  localparam int unsigned UnitLog = LOG2_SEG_BYTES - MIN_LEVEL;
  localparam int unsigned UW      = UnitLog + SegLog;
  localparam int unsigned NLev    = UnitLog + 1;
  localparam int unsigned LIW     = $clog2(NLev);
  localparam int unsigned LW      = bba_pkg::LvlW;
  localparam int unsigned HW      = 4 + LW + 2 * UW;
  localparam int unsigned CW      = $clog2(NUM_SEGMENTS + 1) + 1;
  localparam int unsigned AW      = 32;

  // header fields
  typedef struct packed {
    logic          is_free;
    logic          is_alloc;
    logic [LW-1:0] level;
    logic          has_prev;
    logic          has_next;
    logic [UW-1:0] prev;
    logic [UW-1:0] next;
  } hdr_t;
  // states
  localparam logic [4:0] SIdle  = 5'd0,  SFind  = 5'd1,  SSeg   = 5'd2,
                         SSplit = 5'd3,  SRmRd  = 5'd4,  SRmW1  = 5'd5,
                         SRmPr  = 5'd6,  SRmPw  = 5'd7,  SRmNr  = 5'd8,
                         SRmNw  = 5'd9,  SPsRd  = 5'd10, SPsNw  = 5'd11,
                         SPsW   = 5'd12, SFrRd  = 5'd13, SFrW   = 5'd14,
                         SBdRd  = 5'd15, SBdW   = 5'd16, SOut   = 5'd17,
                         SAfter = 5'd18, SWait  = 5'd19;
  // what to do after a list remove / push
  localparam logic [2:0] KSplitPush2 = 3'd0, KSplitPush1 = 3'd1, KSplitNext = 3'd2,
                         KAllocDone  = 3'd3, KMerge      = 3'd4, KDone      = 3'd5;

  logic [4:0]  st_q, st_d;
  logic [2:0]  kont_q, kont_d;
  logic        op_q;
  logic [LW-1:0] lvl_q, lvl_d, flvl_q, flvl_d;
  logic [UW-1:0] u_q, u_d, u2_q, u2_d, tu_q, tu_d;
  hdr_t        h_q, h_d;
  logic [NLev-1:0] hv_q, hv_d;
  logic [UW-1:0] hu_q [NLev];
  logic [UW-1:0] hu_d [NLev];
  logic [CW-1:0] used_q, used_d;
  logic [2:0]  lim_q;
  logic [13:0] addr_q, addr_d;
  logic [1:0]  stat_q, stat_d;
  logic        we;
  logic [UW-1:0] wa, ra;
  hdr_t        wd;
  logic [HW-1:0] rd_raw;
  hdr_t        rd;

  bba_hdr_mem #(.AW(UW), .DW(HW)) u_mem (
    .clk_i(clk_i), .we_i(we), .waddr_i(wa), .wdata_i(wd),
    .raddr_i(ra), .rdata_o(rd_raw)
  );
  assign rd = hdr_t'(rd_raw);

  function automatic logic [LIW-1:0] lidx(input logic [LW-1:0] l);
    lidx = LIW'(l - LW'(MIN_LEVEL));
  endfunction

  assign req_ready_o = (st_q == SIdle);
  assign cfg_ready_o = (st_q == SIdle);
  assign rsp_valid_o = (st_q == SWait);
  assign data_addr_o = addr_q;
  assign status_o    = stat_q;

  logic [AW-1:0] need, baddr, eff_lim;
  always_comb begin
    st_d = st_q; kont_d = kont_q; lvl_d = lvl_q; flvl_d = flvl_q;
    u_d = u_q; u2_d = u2_q; tu_d = tu_q; h_d = h_q; hv_d = hv_q; hu_d = hu_q;
    used_d = used_q; addr_d = addr_q; stat_d = stat_q;
    we = 1'b0; wa = tu_q; wd = h_q; ra = tu_q;
    need = 32'(req_size_i) + 32'(HEADER_BYTES);
    baddr = 32'(free_addr_i) - 32'(HEADER_BYTES);
    eff_lim = (32'(lim_q) < 32'(NUM_SEGMENTS)) ? 32'(lim_q) : 32'(NUM_SEGMENTS);
    case (st_q)
      SIdle: if (req_valid_i) begin
        addr_d = '0; stat_d = bba_pkg::StOk;
        if (op_i == bba_pkg::OpAlloc) begin
          if (32'(req_size_i) > (32'(1) << LOG2_SEG_BYTES) - 32'(HEADER_BYTES)) begin
            stat_d = bba_pkg::StTooBig; st_d = SWait;
          end else begin
            lvl_d = LW'(LOG2_SEG_BYTES);
            for (int l = LOG2_SEG_BYTES; l >= MIN_LEVEL; l--)
              if ((32'(1) << l) >= need) lvl_d = LW'(l);
            flvl_d = lvl_d; st_d = SFind;
          end
        end else begin
          if (32'(free_addr_i) < 32'(HEADER_BYTES) || baddr[MIN_LEVEL-1:0] != '0 ||
              (baddr >> LOG2_SEG_BYTES) >= 32'(used_q)) begin
            stat_d = bba_pkg::StBadFree; st_d = SWait;
          end else begin
            u_d = UW'(baddr >> MIN_LEVEL); tu_d = u_d; st_d = SFrRd;
          end
        end
      end
      // one level per cycle
      SFind: begin
        if (hv_q[lidx(flvl_q)]) st_d = SSplit;
        else if (flvl_q < LW'(LOG2_SEG_BYTES)) flvl_d = flvl_q + 1'b1;
        else if (32'(used_q) >= eff_lim) begin
          stat_d = bba_pkg::StNoMem; st_d = SWait;
        end else st_d = SSeg;
      end
      SSeg: begin
        tu_d = UW'(32'(used_q) << UnitLog);
        used_d = used_q + 1'b1;
        kont_d = KSplitNext; st_d = SPsRd;
      end
      SSplit: begin
        tu_d = hu_q[lidx(flvl_q)];
        u_d = tu_d;
        if (flvl_q > lvl_q) kont_d = KSplitPush2;
        else kont_d = KAllocDone;
        st_d = SRmRd;
      end
      SAfter: case (kont_q)
        KSplitPush2: begin
          flvl_d = flvl_q - 1'b1;
          tu_d = u_q + (UW'(1) << (flvl_d - LW'(MIN_LEVEL)));
          kont_d = KSplitPush1; st_d = SPsRd;
        end
        KSplitPush1: begin tu_d = u_q; kont_d = KSplitNext; st_d = SPsRd; end
        KSplitNext: st_d = SSplit;
        KAllocDone: begin
          we = 1'b1; wa = u_q; wd = '0; wd.is_alloc = 1'b1; wd.level = lvl_q;
          addr_d = 14'((32'(u_q) << MIN_LEVEL) + 32'(HEADER_BYTES));
          st_d = SWait;
        end
        KMerge: begin
          we = 1'b1; wa = u2_q; wd = '0;
          lvl_d = lvl_q + 1'b1;
          if (u2_q < u_q) u_d = u2_q;
          st_d = SBdRd;
        end
        default: st_d = SWait;
      endcase
      // list remove of tu_q at level flvl_q
      SRmRd: st_d = SRmW1;
      SRmW1: begin
        h_d = rd;
        if (!rd.has_prev) begin
          hv_d[lidx(flvl_q)] = rd.has_next; hu_d[lidx(flvl_q)] = rd.next;
          st_d = SRmNr;
        end else st_d = SRmPr;
        ra = rd.prev;
      end
      SRmPr: begin ra = h_q.prev; st_d = SRmPw; end
      SRmPw: begin
        we = 1'b1; wa = h_q.prev; wd = rd; wd.has_next = h_q.has_next; wd.next = h_q.next;
        st_d = SRmNr;
      end
      SRmNr: begin ra = h_q.next; st_d = h_q.has_next ? SRmNw : SAfter; end
      SRmNw: begin
        we = 1'b1; wa = h_q.next; wd = rd; wd.has_prev = h_q.has_prev; wd.prev = h_q.prev;
        st_d = SAfter;
      end
      // list push of tu_q at level flvl_q
      SPsRd: begin ra = hu_q[lidx(flvl_q)]; st_d = hv_q[lidx(flvl_q)] ? SPsNw : SPsW; end
      SPsNw: begin
        we = 1'b1; wa = hu_q[lidx(flvl_q)]; wd = rd; wd.has_prev = 1'b1; wd.prev = tu_q;
        st_d = SPsW;
      end
      SPsW: begin
        we = 1'b1; wa = tu_q; wd = '0; wd.is_free = 1'b1; wd.level = flvl_q;
        wd.has_next = hv_q[lidx(flvl_q)];
        wd.next = hv_q[lidx(flvl_q)] ? hu_q[lidx(flvl_q)] : '0;
        hv_d[lidx(flvl_q)] = 1'b1; hu_d[lidx(flvl_q)] = tu_q;
        st_d = SAfter;
      end
      SFrRd: st_d = SFrW;
      SFrW: begin
        if (!rd.is_alloc || rd.level < LW'(MIN_LEVEL) || rd.level > LW'(LOG2_SEG_BYTES)) begin
          stat_d = bba_pkg::StBadFree; st_d = SWait;
        end else begin
          we = 1'b1; wa = u_q; wd = '0; lvl_d = rd.level; st_d = SBdRd;
        end
      end
      // buddy check for merge
      SBdRd: begin
        if (lvl_q >= LW'(LOG2_SEG_BYTES)) begin
          flvl_d = lvl_q; tu_d = u_q; kont_d = KDone; st_d = SPsRd;
        end else begin
          u2_d = u_q ^ (UW'(1) << (lvl_q - LW'(MIN_LEVEL)));
          ra = u2_d; st_d = SBdW;
        end
      end
      SBdW: begin
        if (!rd.is_free || rd.level != lvl_q) begin
          flvl_d = lvl_q; tu_d = u_q; kont_d = KDone; st_d = SPsRd;
        end else begin
          flvl_d = lvl_q; tu_d = u2_q; ra = u2_q; kont_d = KMerge; st_d = SRmW1;
        end
      end
      SOut: st_d = SWait;
      SWait: if (rsp_ready_i) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; hv_q <= '0; used_q <= '0; lim_q <= 3'd4; kont_q <= KDone;
    end else begin
      st_q <= st_d; hv_q <= hv_d; used_q <= used_d; kont_q <= kont_d;
      if (cfg_valid_i && cfg_ready_o) lim_q <= segment_limit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d; flvl_q <= flvl_d; u_q <= u_d; u2_q <= u2_d; tu_q <= tu_d;
    h_q <= h_d; hu_q <= hu_d; addr_q <= addr_d; stat_q <= stat_d;
    op_q <= (st_q == SIdle) ? op_i : op_q;
  end

  // a free never reports an address
  a_free_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && op_q == bba_pkg::OpFree) |-> data_addr_o == '0)
    else $error("free returned an address");
  // segment count never passes the segment total
  a_used_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= 32'(NUM_SEGMENTS)) else $error("segment count overflow");
  // result valid and status held while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !rsp_ready_i) |=> rsp_valid_o && $stable(status_o))
    else $error("result dropped");
endmodule
`default_nettype wire
